[design/phtst_pkg.sv]
// Shared widths, register indexes and inter-module types of the polyline hit test.
package phtst_pkg;

  localparam int COORD_BITS = 16;
  localparam int TOL_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Differences of two coordinates, squared length, squared tolerance.
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int LEN_W   = 2 * COORD_BITS + 2;
  localparam int T2_W    = 2 * TOL_W;
  // A cross magnitude at or above 2**CM_W always loses the compare against t^2*len^2.
  localparam int CM_W    = (T2_W + LEN_W - 7) / 2;
  localparam int MUL_A_W = LEN_W + 1;
  localparam int MUL_B_W = CM_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CMP_W   = PROD_W + 8;
  // Coordinates scaled by 16 with the tolerance folded in.
  localparam int BOX_W   = COORD_BITS + 6;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(48);

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(2);

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } phtst_mul_req_t;

  typedef struct packed {
    logic                         update;
    logic                         clear;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } phtst_box_ctl_t;

endpackage

[design/phtst_vertex_if.sv]
// Vertex request channel: valid/ready handshake with one projected vertex.
interface phtst_vertex_if import phtst_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         vertex_valid;
  logic                         contour_start;
  logic                         last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_valid, contour_start,
                  last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_valid, contour_start,
                  last_vertex, output ready);
endinterface

[design/phtst_result_if.sv]
// Result request channel: valid/ready handshake with the hit answer.
interface phtst_result_if;
  logic valid;
  logic ready;
  logic hit;
  logic hit_by_segment;

  modport source (output valid, hit, hit_by_segment, input ready);
  modport sink   (input valid, hit, hit_by_segment, output ready);
endinterface

[design/phtst_cfg_if.sv]
// Configuration write channel: valid/ready handshake with register index and data.
interface phtst_cfg_if import phtst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/phtst_mul.sv]
// Shared signed multiplier with a registered product.
module phtst_mul import phtst_pkg::*; (
  input  logic                      clk,
  input  phtst_mul_req_t            req,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a) * PROD_W'(req.b);
  end

endmodule

[design/phtst_box.sv]
// Bounding box of the valid vertices and the tolerance-widened inside test.
module phtst_box import phtst_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  phtst_box_ctl_t               ctl,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic [TOL_W-1:0]             tolerance,
  output logic                         in_box
);

  logic                         present;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] max_y;

  logic signed [BOX_W-1:0] tol_s;
  logic signed [BOX_W-1:0] qx_s;
  logic signed [BOX_W-1:0] qy_s;
  logic signed [BOX_W-1:0] lo_x;
  logic signed [BOX_W-1:0] hi_x;
  logic signed [BOX_W-1:0] lo_y;
  logic signed [BOX_W-1:0] hi_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
      min_x   <= '0;
      max_x   <= '0;
      min_y   <= '0;
      max_y   <= '0;
    end else if (ctl.clear) begin
      present <= 1'b0;
    end else if (ctl.update) begin
      present <= 1'b1;
      if (!present || ctl.x < min_x) min_x <= ctl.x;
      if (!present || ctl.x > max_x) max_x <= ctl.x;
      if (!present || ctl.y < min_y) min_y <= ctl.y;
      if (!present || ctl.y > max_y) max_y <= ctl.y;
    end
  end

  always_comb begin
    tol_s  = BOX_W'(tolerance);
    qx_s   = BOX_W'(query_x) <<< 4;
    qy_s   = BOX_W'(query_y) <<< 4;
    lo_x   = (BOX_W'(min_x) <<< 4) - tol_s;
    hi_x   = (BOX_W'(max_x) <<< 4) + tol_s;
    lo_y   = (BOX_W'(min_y) <<< 4) - tol_s;
    hi_y   = (BOX_W'(max_y) <<< 4) + tol_s;
    in_box = present && (qx_s >= lo_x) && (qx_s <= hi_x)
                     && (qy_s >= lo_y) && (qy_s <= hi_y);
  end

endmodule

[design/phtst_seq.sv]
// Sequencer: vertex intake, segment distance steps on the shared multiplier, result register.
module phtst_seq import phtst_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  phtst_vertex_if.sink                 vertex,
  phtst_result_if.source               result,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic [TOL_W-1:0]             tolerance,
  output phtst_mul_req_t               mul_req,
  input  logic signed [PROD_W-1:0]     prod,
  output phtst_box_ctl_t               box_ctl,
  input  logic                         box_inside
);

  typedef enum logic [4:0] {
    S_IDLE, S_T2, S_LA, S_LB, S_DA, S_DB, S_DEC,
    S_PA, S_PB, S_PC,
    S_CA, S_CB, S_CC, S_CD, S_CE, S_CF,
    S_BOX, S_EMIT
  } state_t;

  state_t state;

  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic                         prev_live;
  logic                         already_answered;
  logic                         last_flag;
  logic                         use_end;
  logic signed [DIFF_W-1:0]     dx;
  logic signed [DIFF_W-1:0]     dy;
  logic signed [DIFF_W-1:0]     px;
  logic signed [DIFF_W-1:0]     py;
  logic signed [DIFF_W-1:0]     ex;
  logic signed [DIFF_W-1:0]     ey;
  logic [T2_W-1:0]              t2;
  logic [LEN_W-1:0]             len2;
  logic signed [PROD_W-1:0]     acc;
  logic [CM_W-1:0]              cm;
  logic                         cm_big;
  logic                         pend_hit;
  logic                         pend_seg;
  logic                         out_valid;
  logic                         out_hit;
  logic                         out_seg;

  logic                         accept;
  logic                         hp;
  logic signed [PROD_W-1:0]     sum;
  logic signed [PROD_W-1:0]     cross_v;
  logic signed [PROD_W-1:0]     cabs;
  logic [CMP_W-1:0]             lhs;
  logic [CMP_W-1:0]             rhs;
  logic                         near_pt;
  logic                         near_cross;
  logic                         seg_done;
  logic                         seg_near;
  logic signed [DIFF_W-1:0]     pa;
  logic signed [DIFF_W-1:0]     pb;

  assign vertex.ready   = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.hit     = out_hit;
  assign result.hit_by_segment = out_seg;

  always_comb begin
    accept     = vertex.valid && vertex.ready;
    hp         = prev_live && !vertex.contour_start;
    sum        = acc + prod;
    cross_v    = acc - prod;
    cabs       = cross_v[PROD_W-1] ? -cross_v : cross_v;
    lhs        = CMP_W'($unsigned(acc)) << 8;
    rhs        = CMP_W'($unsigned(prod));
    near_pt    = $unsigned(sum) <= PROD_W'(t2 >> 8);
    near_cross = !cm_big && (lhs <= rhs);
    seg_done   = (state == S_PC) || (state == S_CF);
    seg_near   = (state == S_PC) ? near_pt : near_cross;
    pa         = use_end ? ex : px;
    pb         = use_end ? ey : py;

    box_ctl.update = accept && !already_answered && vertex.vertex_valid;
    box_ctl.clear  = (accept && already_answered && vertex.last_vertex)
                  || (state == S_BOX)
                  || (seg_done && seg_near && last_flag);
    box_ctl.x      = vertex.vertex_x;
    box_ctl.y      = vertex.vertex_y;
  end

  // Multiplier operands for each step of the sequence.
  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state)
      S_T2: begin
        mul_req.a = MUL_A_W'(tolerance);
        mul_req.b = MUL_B_W'(tolerance);
      end
      S_LA: begin
        mul_req.a = MUL_A_W'(dx);
        mul_req.b = MUL_B_W'(dx);
      end
      S_LB: begin
        mul_req.a = MUL_A_W'(dy);
        mul_req.b = MUL_B_W'(dy);
      end
      S_DA: begin
        mul_req.a = MUL_A_W'(px);
        mul_req.b = MUL_B_W'(dx);
      end
      S_DB: begin
        mul_req.a = MUL_A_W'(py);
        mul_req.b = MUL_B_W'(dy);
      end
      S_PA: begin
        mul_req.a = MUL_A_W'(pa);
        mul_req.b = MUL_B_W'(pa);
      end
      S_PB: begin
        mul_req.a = MUL_A_W'(pb);
        mul_req.b = MUL_B_W'(pb);
      end
      S_CA: begin
        mul_req.a = MUL_A_W'(px);
        mul_req.b = MUL_B_W'(dy);
      end
      S_CB: begin
        mul_req.a = MUL_A_W'(py);
        mul_req.b = MUL_B_W'(dx);
      end
      S_CD: begin
        mul_req.a = MUL_A_W'(cm);
        mul_req.b = MUL_B_W'(cm);
      end
      S_CE: begin
        mul_req.a = MUL_A_W'(len2);
        mul_req.b = MUL_B_W'(t2);
      end
      S_IDLE, S_DEC, S_PC, S_CC, S_CF, S_BOX, S_EMIT: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      prev_live        <= 1'b0;
      already_answered <= 1'b0;
      out_valid        <= 1'b0;
      prev_x           <= '0;
      prev_y           <= '0;
    end else begin
      // drop a taken result unless a new one is loaded this cycle
      if (result.ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_x     <= vertex.vertex_x;
            cur_y     <= vertex.vertex_y;
            last_flag <= vertex.last_vertex;
            dx <= DIFF_W'(vertex.vertex_x) - DIFF_W'(prev_x);
            dy <= DIFF_W'(vertex.vertex_y) - DIFF_W'(prev_y);
            px <= DIFF_W'(query_x) - DIFF_W'(prev_x);
            py <= DIFF_W'(query_y) - DIFF_W'(prev_y);
            ex <= DIFF_W'(query_x) - DIFF_W'(vertex.vertex_x);
            ey <= DIFF_W'(query_y) - DIFF_W'(vertex.vertex_y);
            if (already_answered) begin
              // drop everything until the last vertex closes the query
              if (vertex.last_vertex) begin
                already_answered <= 1'b0;
                prev_live        <= 1'b0;
              end
            end else if (!vertex.vertex_valid) begin
              prev_live <= 1'b0;
              state     <= vertex.last_vertex ? S_BOX : S_IDLE;
            end else if (hp) begin
              state <= S_T2;
            end else begin
              prev_x    <= vertex.vertex_x;
              prev_y    <= vertex.vertex_y;
              prev_live <= 1'b1;
              state     <= vertex.last_vertex ? S_BOX : S_IDLE;
            end
          end
        end
        S_T2: state <= S_LA;
        S_LA: begin
          t2    <= T2_W'($unsigned(prod));
          state <= S_LB;
        end
        S_LB: begin
          acc   <= prod;
          state <= S_DA;
        end
        S_DA: begin
          len2  <= LEN_W'($unsigned(sum));
          state <= S_DB;
        end
        S_DB: begin
          acc   <= prod;
          state <= S_DEC;
        end
        S_DEC: begin
          // sum holds the dot product here
          if (len2 == '0 || sum[PROD_W-1] || sum == '0) begin
            use_end <= 1'b0;
            state   <= S_PA;
          end else if (sum >= $signed(PROD_W'(len2))) begin
            use_end <= 1'b1;
            state   <= S_PA;
          end else begin
            state <= S_CA;
          end
        end
        S_PA: state <= S_PB;
        S_PB: begin
          acc   <= prod;
          state <= S_PC;
        end
        S_CA: state <= S_CB;
        S_CB: begin
          acc   <= prod;
          state <= S_CC;
        end
        S_CC: begin
          cm     <= cabs[CM_W-1:0];
          cm_big <= |cabs[PROD_W-1:CM_W];
          state  <= S_CD;
        end
        S_CD: state <= S_CE;
        S_CE: begin
          acc   <= prod;
          state <= S_CF;
        end
        S_PC, S_CF: begin
          if (seg_near) begin
            pend_hit <= 1'b1;
            pend_seg <= 1'b1;
            state    <= S_EMIT;
            if (last_flag) begin
              prev_live        <= 1'b0;
              already_answered <= 1'b0;
            end else begin
              already_answered <= 1'b1;
            end
          end else begin
            prev_x    <= cur_x;
            prev_y    <= cur_y;
            prev_live <= 1'b1;
            state     <= last_flag ? S_BOX : S_IDLE;
          end
        end
        S_BOX: begin
          pend_hit         <= box_inside;
          pend_seg         <= 1'b0;
          prev_live        <= 1'b0;
          already_answered <= 1'b0;
          state            <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_hit   <= pend_hit;
            out_seg   <= pend_seg;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[design/polyline_screen_hit_test.sv]
// Top level of the screen-space polyline hit test: configuration registers and block wiring.
//
// Streams projected vertices of one query and answers whether the configured query point
// lies within the Q8.4 tolerance of any segment joining consecutive valid vertices of a
// contour, using an exact squared-integer, division-free clamped distance test. The first
// segment hit answers (hit=1, hit_by_segment=1) at once and the remaining vertices up to
// the last one are swallowed; otherwise the last vertex answers with the test against the
// tolerance-widened bounding box of all valid vertices (hit_by_segment=0). One vertex is
// worked on at a time and the vertex channel is not ready meanwhile. All products run
// through a single registered multiplier under a small sequencer, so the work per vertex is
// set by the products it needs: none for an invalid vertex or one that opens a chain; t^2,
// the squared length, the dot product and two squares when the segment test ends on an
// endpoint distance; t^2, the squared length, the dot product, the cross product, its square
// and t^2 times the squared length for the perpendicular cross-product compare. A segment
// hit then loads the result request; a vertex that closes the query without a segment hit
// runs the box test first. Results leave through an output register; the sequencer waits
// only if that register still holds an untaken result. Configuration writes are always
// ready and are meant for idle periods between queries. No clearing pass follows reset.
module polyline_screen_hit_test import phtst_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  phtst_vertex_if.sink   vertex,
  phtst_result_if.source result,
  phtst_cfg_if.sink      cfg
);

  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic [TOL_W-1:0]             tolerance;

  phtst_mul_req_t               mul_req;
  logic signed [PROD_W-1:0]     prod;
  phtst_box_ctl_t               box_ctl;
  logic                         box_inside;

  // Take every configuration write at once; indexes past the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x   <= '0;
      query_y   <= '0;
      tolerance <= TOL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_QUERY_X:   query_x   <= COORD_BITS'(cfg.data);
        REG_QUERY_Y:   query_y   <= COORD_BITS'(cfg.data);
        REG_TOLERANCE: tolerance <= cfg.data[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: owns the handshakes, the chain state and the step order.
  phtst_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .vertex     (vertex),
    .result     (result),
    .query_x    (query_x),
    .query_y    (query_y),
    .tolerance  (tolerance),
    .mul_req    (mul_req),
    .prod       (prod),
    .box_ctl    (box_ctl),
    .box_inside (box_inside)
  );

  // The one multiplier every squared term goes through.
  phtst_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // Running bounding box, updated as each valid vertex is accepted.
  phtst_box u_box (
    .clk       (clk),
    .rst       (rst),
    .ctl       (box_ctl),
    .query_x   (query_x),
    .query_y   (query_y),
    .tolerance (tolerance),
    .in_box    (box_inside)
  );

endmodule

[sim/tb_polyline_screen_hit_test.sv]
// Self-checking testbench for the screen-space polyline hit test, with its own hit predictor.
module tb_polyline_screen_hit_test;
  import phtst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  // Covers the longest vertex: the perpendicular compare, then the box test and result request.
  localparam int SETTLE_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 40;
  localparam int ITEMS_PER_PHASE = 25;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                           ok;
    bit                           start;
    bit                           last;
  } vertex_t;

  typedef struct {
    bit hit;
    bit by_segment;
  } answer_t;

  logic clk;
  logic rst;

  phtst_vertex_if vtx_ch ();
  phtst_result_if res_ch ();
  phtst_cfg_if    cfg_ch ();

  polyline_screen_hit_test dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vtx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Answers predicted for accepted vertices, oldest first.
  answer_t pending_answers[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  // Set for stretches where neither side may stall.
  bit      no_stall;

  // Predictor copy of the registers.
  longint  cfg_qx;
  longint  cfg_qy;
  longint  cfg_tol;

  // Predictor copy of the query state.
  longint  prev_x;
  longint  prev_y;
  bit      chain_open;
  bit      box_seen;
  longint  box_lo_x;
  longint  box_hi_x;
  longint  box_lo_y;
  longint  box_hi_y;
  bit      answered;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Hit predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_query_state();
    chain_open = 1'b0;
    box_seen   = 1'b0;
    answered   = 1'b0;
  endfunction

  // Compare 256*d^2 against T^2 for the distance to a single point.
  function automatic bit point_within(input longint ex, input longint ey, input longint t2);
    longint d2;
    d2 = ex * ex + ey * ey;
    return d2 * 256 <= t2;
  endfunction

  // Clamped point-to-segment test, exact and division-free.
  function automatic bit segment_within(input longint qx, input longint qy,
                                        input longint sx, input longint sy,
                                        input longint ex, input longint ey,
                                        input longint t);
    longint       dx, dy, px, py, t2, len2, dotp, crs;
    logic [127:0] cm, tt, ll, lhs, rhs;
    dx   = ex - sx;
    dy   = ey - sy;
    px   = qx - sx;
    py   = qy - sy;
    t2   = t * t;
    len2 = dx * dx + dy * dy;
    // Degenerate segment: measure to its start.
    if (len2 == 0) return point_within(px, py, t2);
    dotp = px * dx + py * dy;
    // Projection falls before the start or past the end: clamp to that endpoint.
    if (dotp <= 0) return point_within(px, py, t2);
    if (dotp >= len2) return point_within(qx - ex, qy - ey, t2);
    // Interior: 256*cross^2 <= T^2*len^2, widened so nothing overflows.
    crs = px * dy - py * dx;
    if (crs < 0) crs = -crs;
    cm  = 128'(crs);
    tt  = 128'(t2);
    ll  = 128'(len2);
    lhs = cm * cm * 256;
    rhs = tt * ll;
    return lhs <= rhs;
  endfunction

  // Advance the predictor by one accepted vertex; return 1 when it yields an answer.
  function automatic bit predict_answer(input vertex_t v, output answer_t ans);
    longint vx, vy;
    bit     in_box;
    vx  = longint'(v.x);
    vy  = longint'(v.y);
    ans = '{hit: 1'b0, by_segment: 1'b0};
    // Query already settled by a segment hit: swallow up to the last vertex.
    if (answered) begin
      if (v.last) clear_query_state();
      return 1'b0;
    end
    if (v.start) chain_open = 1'b0;
    if (!v.ok) begin
      // Broken projection cuts the chain and leaves the box alone.
      chain_open = 1'b0;
    end else begin
      if (!box_seen) begin
        box_lo_x = vx;
        box_hi_x = vx;
        box_lo_y = vy;
        box_hi_y = vy;
        box_seen = 1'b1;
      end else begin
        if (vx < box_lo_x) box_lo_x = vx;
        if (vx > box_hi_x) box_hi_x = vx;
        if (vy < box_lo_y) box_lo_y = vy;
        if (vy > box_hi_y) box_hi_y = vy;
      end
      if (chain_open && segment_within(cfg_qx, cfg_qy, prev_x, prev_y, vx, vy, cfg_tol))
      begin
        ans = '{hit: 1'b1, by_segment: 1'b1};
        if (v.last) clear_query_state();
        else answered = 1'b1;
        return 1'b1;
      end
      prev_x     = vx;
      prev_y     = vy;
      chain_open = 1'b1;
    end
    if (!v.last) return 1'b0;
    // No segment hit: fall back to the tolerance-widened bounding box.
    in_box = box_seen
      && cfg_qx * 16 >= box_lo_x * 16 - cfg_tol && cfg_qx * 16 <= box_hi_x * 16 + cfg_tol
      && cfg_qy * 16 >= box_lo_y * 16 - cfg_tol && cfg_qy * 16 <= box_hi_y * 16 + cfg_tol;
    ans.hit = in_box;
    clear_query_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Coordinate near a center, clamped to the coordinate range; span 0 means anywhere.
  function automatic int near_coord(input int c, input int span);
    int v;
    if (span == 0) return int'($urandom_range(0, 65535)) - 32768;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // Offer one vertex request, hold it until taken, then predict its answer.
  task automatic send_vertex(input int x, input int y, input bit ok, input bit start,
                             input bit last);
    vertex_t v;
    answer_t ans;
    int      gap;
    v.x     = COORD_BITS'(x);
    v.y     = COORD_BITS'(y);
    v.ok    = ok;
    v.start = start;
    v.last  = last;
    gap     = pick_gap();
    if (gap > 0) begin
      vtx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_ch.valid         <= 1'b1;
    vtx_ch.vertex_x      <= v.x;
    vtx_ch.vertex_y      <= v.y;
    vtx_ch.vertex_valid  <= ok;
    vtx_ch.contour_start <= start;
    vtx_ch.last_vertex   <= last;
    do @(posedge clk); while (!vtx_ch.ready);
    if (predict_answer(v, ans)) pending_answers = {pending_answers, ans};
  endtask

  // Write one register; the caller drops valid once its burst of writes is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_QUERY_X:   cfg_qx  = longint'($signed(data));
      REG_QUERY_Y:   cfg_qy  = longint'($signed(data));
      REG_TOLERANCE: cfg_tol = longint'(data[TOL_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_query(input int qx, input int qy, input logic [CFG_DATA_W-1:0] tol_word);
    write_reg(REG_QUERY_X, CFG_DATA_W'(qx));
    write_reg(REG_QUERY_Y, CFG_DATA_W'(qy));
    write_reg(REG_TOLERANCE, tol_word);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop the vertex request, drain every predicted answer, then let the block go quiet.
  task automatic settle_block();
    vtx_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: query at the origin, tolerance of 3 pixels.
  task automatic test_directed_geometry();
    // Query with no valid vertex at all: a miss.
    send_vertex(0, 0, 1'b0, 1'b1, 1'b1);
    // Lone valid vertex: box test only.
    send_vertex(3, 0, 1'b1, 1'b1, 1'b1);
    // Zero-length segment, point 2 px away.
    send_vertex(2, 0, 1'b1, 1'b1, 1'b0);
    send_vertex(2, 0, 1'b1, 1'b0, 1'b1);
    // Projection before the start misses, then projection past the end hits.
    send_vertex(5, 0, 1'b1, 1'b1, 1'b0);
    send_vertex(10, 0, 1'b1, 1'b0, 1'b0);
    send_vertex(2, 0, 1'b1, 1'b0, 1'b1);
    // Early segment hit; the rest of the query is swallowed.
    send_vertex(-100, 2, 1'b1, 1'b1, 1'b0);
    send_vertex(100, 2, 1'b1, 1'b0, 1'b0);
    send_vertex(0, 0, 1'b1, 1'b0, 1'b0);
    send_vertex(7, 7, 1'b0, 1'b0, 1'b1);
    // Invalid vertex breaks a chain that would pass through the point.
    send_vertex(-100, 10, 1'b1, 1'b1, 1'b0);
    send_vertex(0, 0, 1'b0, 1'b0, 1'b0);
    send_vertex(100, -10, 1'b1, 1'b0, 1'b1);
    // Contour start breaks the same chain.
    send_vertex(-100, 10, 1'b1, 1'b1, 1'b0);
    send_vertex(100, -10, 1'b1, 1'b1, 1'b1);
    // Perpendicular distance exactly equal to the tolerance.
    send_vertex(-50, 3, 1'b1, 1'b1, 1'b0);
    send_vertex(50, 3, 1'b1, 1'b0, 1'b1);
    settle_block();
  endtask

  task automatic test_extreme_registers();
    // Full-range diagonal with the widest tolerance.
    set_query(-32768, 32767, CFG_DATA_W'(4095));
    send_vertex(-32768, -32768, 1'b1, 1'b1, 1'b0);
    send_vertex(32767, 32767, 1'b1, 1'b0, 1'b1);
    settle_block();
    // Zero tolerance: only exact coincidence counts.
    set_query(32767, -32768, CFG_DATA_W'(0));
    send_vertex(32767, -32768, 1'b1, 1'b1, 1'b1);
    send_vertex(32767, -32768, 1'b1, 1'b1, 1'b0);
    send_vertex(32767, -32768, 1'b1, 1'b0, 1'b1);
    send_vertex(32766, 0, 1'b1, 1'b1, 1'b1);
    settle_block();
    // Write to the unused index, and a tolerance word with its upper bits set.
    write_reg(REG_UNUSED, '1);
    set_query(0, 0, 16'hF030);
    send_vertex(0, 3, 1'b1, 1'b1, 1'b0);
    send_vertex(0, -3, 1'b1, 1'b0, 1'b1);
    settle_block();
  endtask

  // Well-formed queries clustered around the query point, with some broken ones mixed in.
  task automatic test_random_queries();
    int                    phase, i, sent, n, span, qx, qy, r, tol;
    bit                    broken, ok, start, last;
    logic [CFG_DATA_W-1:0] tol_word;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_stall = ($urandom_range(0, 5) == 0);
      r  = $urandom_range(0, 9);
      qx = (r == 0) ? -32768 : (r == 1) ? 32767 : int'($urandom_range(0, 65535)) - 32768;
      r  = $urandom_range(0, 9);
      qy = (r == 0) ? -32768 : (r == 1) ? 32767 : int'($urandom_range(0, 65535)) - 32768;
      r  = $urandom_range(0, 9);
      case (r)
        0:       tol = 0;
        1:       tol = 4095;
        2, 3, 4: tol = $urandom_range(0, 64);
        default: tol = $urandom_range(0, 4095);
      endcase
      tol_word = {4'($urandom), 12'(tol)};
      set_query(qx, qy, tol_word);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        r = $urandom_range(0, 9);
        span   = (r < 4) ? 4 : (r < 7) ? 40 : (r < 9) ? 400 : 0;
        broken = ($urandom_range(0, 9) == 0);
        for (i = 0; i < n; i++) begin
          if (broken) begin
            ok    = 1'($urandom_range(0, 1));
            start = 1'($urandom_range(0, 1));
            last  = (i == n - 1) || ($urandom_range(0, 7) == 0);
          end else begin
            ok    = ($urandom_range(0, 9) != 0);
            start = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 9) == 0);
            last  = (i == n - 1);
          end
          send_vertex(near_coord(qx, span), near_coord(qy, span), ok, start, last);
        end
        sent += n;
      end
      settle_block();
    end
    no_stall = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and checking
  // ---------------------------------------------------------------------------

  initial begin : result_backpressure
    int hold;
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Compare every taken result with the oldest prediction.
  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result hit=%0b hit_by_segment=%0b", $time,
                 res_ch.hit, res_ch.hit_by_segment);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (res_ch.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, res_ch.hit);
          mismatches++;
        end
        if (res_ch.hit_by_segment !== want.by_segment) begin
          $display("%0t: hit_by_segment expected %0b actual %0b", $time, want.by_segment,
                   res_ch.hit_by_segment);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: count cycles in which no channel moves a request.
  always @(posedge clk) begin
    if (rst || (vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("polyline_screen_hit_test test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    rst                  = 1'b1;
    vtx_ch.valid         = 1'b0;
    vtx_ch.vertex_x      = '0;
    vtx_ch.vertex_y      = '0;
    vtx_ch.vertex_valid  = 1'b0;
    vtx_ch.contour_start = 1'b0;
    vtx_ch.last_vertex   = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    no_stall             = 1'b0;
    // Predictor starts from the reset state of the block.
    cfg_qx   = 0;
    cfg_qy   = 0;
    cfg_tol  = longint'(TOL_RESET);
    prev_x   = 0;
    prev_y   = 0;
    box_lo_x = 0;
    box_hi_x = 0;
    box_lo_y = 0;
    box_hi_y = 0;
    clear_query_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_geometry();
    test_extreme_registers();
    test_random_queries();

    // Drain, then give a stray late result the chance to show up.
    settle_block();
    if (mismatches == 0) begin
      $display("polyline_screen_hit_test test passed");
    end else begin
      $display("polyline_screen_hit_test test failed");
    end
    $finish;
  end

endmodule
